// ===== hdl/nrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// nrgb_pkg
// Shared types and constants for the normal vector to color pipeline.
// ----------------------------------------------------------------------------
package nrgb_pkg;

    // component width of the incoming normal (Q2.14 at 16 bits)
    localparam int CW = 16;
    // width of the squared length x^2 + y^2 + z^2
    localparam int SW = 2 * CW + 2;
    // width of 16129 * a^2
    localparam int KW = 2 * CW + 14;
    // width of trial^2 * s
    localparam int PW = SW + 14;
    // number of bisection steps for a channel magnitude of 0..127
    localparam int STEPS = 7;
    localparam int TW = STEPS;
    localparam int T2W = 2 * STEPS;

    localparam logic [KW-1:0] SCALE_SQ = KW'(16129);
    localparam logic [7:0] WHITE = 8'd255;
    localparam logic [7:0] MID = 8'd127;
    localparam logic [7:0] MID_NEG = 8'd126;

    // per channel search state
    typedef struct packed {
        logic           neg;
        logic [KW-1:0]  k;
        logic [TW-1:0]  t;
        logic [T2W-1:0] t2;
    } t_chan;

    // one item travelling down the search stages
    typedef struct packed {
        logic            vld;
        logic            white;
        logic [SW-1:0]   s;
        t_chan [2:0]     ch;
    } t_item;

endpackage

// ===== hdl/normal_to_rgb_color_core.sv =====
// Ten register stages in all lie between the edge that accepts a request and
// the first edge at which its color can be taken.
// Throughput: one request per cycle; each channel magnitude is found by a
// seven stage bisection, one bit per stage, all stages advancing together.
// A stalled output freezes the whole pipeline; o_s_tready is ~r_vld | i_m_tready.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not cleared.
// ----------------------------------------------------------------------------
// normal_to_rgb_color_core
// Maps a surface normal to a color, 127 + 127 * n / |n| per channel.
// ----------------------------------------------------------------------------
module normal_to_rgb_color_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // x, y, z components
    input  logic [3*nrgb_pkg::CW-1:0] i_s_tdata,
    // valid flag of the normal
    input  logic                      i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // red, green, blue, packed_color
    output logic [47:0]               o_m_tdata
);

    logic            w_en;
    nrgb_pkg::t_item w_stage [nrgb_pkg::STEPS+1];
    logic            r_vld;
    logic [7:0]      r_rgb [3];
    logic [7:0]      n_rgb [3];

    // whole pipeline moves unless the output holds an untaken result
    assign w_en = ~r_vld | i_m_tready;
    assign o_s_tready = w_en;

    nrgb_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_vld          (i_s_tvalid),
        .i_normal_valid (i_s_tuser),
        .i_comp         (i_s_tdata),
        .o_item         (w_stage[0])
    );

    // bisection stages, most significant bit first
    for (genvar g = 0; g < nrgb_pkg::STEPS; g++) begin : g_step
        nrgb_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bit   (3'(nrgb_pkg::STEPS - 1 - g)),
            .i_item  (w_stage[g]),
            .o_item  (w_stage[g+1])
        );
    end

    // final channel values
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_stage[nrgb_pkg::STEPS].white) begin
                n_rgb[i] = nrgb_pkg::WHITE;
            end else if (w_stage[nrgb_pkg::STEPS].ch[i].neg) begin
                n_rgb[i] = nrgb_pkg::MID_NEG - 8'(w_stage[nrgb_pkg::STEPS].ch[i].t);
            end else begin
                n_rgb[i] = nrgb_pkg::MID + 8'(w_stage[nrgb_pkg::STEPS].ch[i].t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_stage[nrgb_pkg::STEPS].vld;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rgb[i] <= n_rgb[i];
            end
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata = {r_rgb[0], r_rgb[1], r_rgb[2], r_rgb[2], r_rgb[1], r_rgb[0]};

`ifndef SYNTHESIS
    // packed color mirrors the separate channels
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:24] == {o_m_tdata[7:0], o_m_tdata[15:8],
                                             o_m_tdata[23:16]}))
        else $error("packed color differs from channels");
    // a channel at 255 only comes from the white case
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[7:0] == 8'd255) |->
            (o_m_tdata[15:8] == 8'd255 && o_m_tdata[23:16] == 8'd255))
        else $error("partial white color");
    // nothing leaves right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ===== hdl/nrgb_prep.sv =====
// ----------------------------------------------------------------------------
// nrgb_prep
// Two register stages: magnitudes and squares, then length and bound terms.
// ----------------------------------------------------------------------------
module nrgb_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic                  i_normal_valid,
    input  logic [3*nrgb_pkg::CW-1:0] i_comp,
    output nrgb_pkg::t_item       o_item
);

    logic                       r_a_vld;
    logic                       r_a_white;
    logic [2:0]                 r_a_neg;
    logic [2*nrgb_pkg::CW-1:0]  r_a_sq [3];
    logic [2*nrgb_pkg::CW-1:0]  n_a_sq [3];
    logic [2:0]                 n_a_neg;
    logic [nrgb_pkg::SW-1:0]    n_s;
    nrgb_pkg::t_item            r_item;
    nrgb_pkg::t_item            n_item;

    // stage a: absolute values and squares
    always_comb begin
        logic [nrgb_pkg::CW-1:0] c;
        logic [nrgb_pkg::CW-1:0] a;
        for (int i = 0; i < 3; i++) begin
            c = i_comp[i*nrgb_pkg::CW +: nrgb_pkg::CW];
            n_a_neg[i] = c[nrgb_pkg::CW-1];
            a = n_a_neg[i] ? (~c + 1'b1) : c;
            n_a_sq[i] = (2*nrgb_pkg::CW)'(a) * (2*nrgb_pkg::CW)'(a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
        if (i_en) begin
            r_a_white <= ~i_normal_valid;
            r_a_neg <= n_a_neg;
            for (int i = 0; i < 3; i++) begin
                r_a_sq[i] <= n_a_sq[i];
            end
        end
    end

    // stage b: squared length and 16129 * a^2 per channel
    always_comb begin
        n_s = nrgb_pkg::SW'(r_a_sq[0]) + nrgb_pkg::SW'(r_a_sq[1])
            + nrgb_pkg::SW'(r_a_sq[2]);
        n_item.vld = r_a_vld;
        n_item.white = r_a_white | (n_s == '0);
        n_item.s = n_s;
        for (int i = 0; i < 3; i++) begin
            n_item.ch[i].neg = r_a_neg[i];
            n_item.ch[i].k = nrgb_pkg::KW'(r_a_sq[i]) * nrgb_pkg::SCALE_SQ;
            n_item.ch[i].t = '0;
            n_item.ch[i].t2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item.vld <= n_item.vld;
        end
        if (i_en) begin
            r_item.white <= n_item.white;
            r_item.s <= n_item.s;
            r_item.ch <= n_item.ch;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/nrgb_step.sv =====
// ----------------------------------------------------------------------------
// nrgb_step
// One bisection stage: tries one more magnitude bit on all three channels.
// ----------------------------------------------------------------------------
module nrgb_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [2:0]      i_bit,
    input  nrgb_pkg::t_item i_item,
    output nrgb_pkg::t_item o_item
);

    nrgb_pkg::t_item r_item;
    nrgb_pkg::t_item n_item;

    // trial^2 built from the kept square, then compared against the bound
    always_comb begin
        logic [nrgb_pkg::TW-1:0]  trial;
        logic [nrgb_pkg::T2W-1:0] trial2;
        logic [nrgb_pkg::PW-1:0]  prod;
        logic                     keep;
        n_item = i_item;
        for (int i = 0; i < 3; i++) begin
            trial = i_item.ch[i].t | (nrgb_pkg::TW'(1) << i_bit);
            trial2 = i_item.ch[i].t2
                   + (nrgb_pkg::T2W'(i_item.ch[i].t) << (i_bit + 3'd1))
                   + (nrgb_pkg::T2W'(1) << {i_bit, 1'b0});
            prod = nrgb_pkg::PW'(trial2) * nrgb_pkg::PW'(i_item.s);
            // negative side needs strict inequality
            keep = i_item.ch[i].neg ? (prod < nrgb_pkg::PW'(i_item.ch[i].k))
                                    : (prod <= nrgb_pkg::PW'(i_item.ch[i].k));
            if (keep) begin
                n_item.ch[i].t = trial;
                n_item.ch[i].t2 = trial2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item.vld <= n_item.vld;
        end
        if (i_en) begin
            r_item.white <= n_item.white;
            r_item.s <= n_item.s;
            r_item.ch <= n_item.ch;
        end
    end

    assign o_item = r_item;

endmodule
